// ----- src/plb_pkg.sv -----
// Shared types, constants and helpers for the price level book.
`default_nettype none

package plb_pkg;

  // Book geometry and field widths
  localparam int unsigned LEVELS   = 100;
  localparam int unsigned PRICE_W  = 7;
  localparam int unsigned QTY_W    = 31;
  localparam int unsigned CHG_W    = 32;
  localparam int unsigned SPREAD_W = 8;
  localparam int unsigned MID_W    = 8;

  typedef logic [PRICE_W-1:0] price_t;
  typedef logic [QTY_W-1:0]   qty_t;

  localparam price_t PRICE_MIN = 7'd1;
  localparam price_t PRICE_MAX = 7'd99;
  localparam price_t PRICE_PAR = 7'd100;
  localparam qty_t   QTY_MAX   = '1;

  typedef enum logic {
    CMD_DELTA = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_e;

  typedef enum logic {
    SIDE_YES = 1'b0,
    SIDE_NO  = 1'b1
  } side_e;

  // Level write request: set stores qty and marks present, else erases
  typedef struct packed {
    logic   we;
    logic   set;
    price_t addr;
    qty_t   qty;
  } lvl_wr_t;

  // Highest present level of one side
  typedef struct packed {
    logic   present;
    price_t price;
  } top_t;

  function automatic logic price_in_range(price_t p);
    return (p >= PRICE_MIN) && (p <= PRICE_MAX);
  endfunction

endpackage

`default_nettype wire

// ----- src/plb_if.sv -----
// Valid/ready channel interfaces for book updates and top-of-book results.
`default_nettype none

interface plb_in_if;
  import plb_pkg::*;

  logic               valid;
  logic               ready;
  logic               command;
  logic               side;
  logic [PRICE_W-1:0] price;
  logic [CHG_W-1:0]   quantity_change;

  modport source (output valid, command, side, price, quantity_change, input ready);
  modport sink   (input valid, command, side, price, quantity_change, output ready);
endinterface

interface plb_out_if;
  import plb_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       bid_valid;
  logic [PRICE_W-1:0]         bid_price;
  logic [QTY_W-1:0]           bid_quantity;
  logic                       ask_valid;
  logic [PRICE_W-1:0]         ask_price;
  logic [QTY_W-1:0]           ask_quantity;
  logic signed [SPREAD_W-1:0] spread;
  logic [MID_W-1:0]           mid_doubled;

  modport source (output valid, bid_valid, bid_price, bid_quantity, ask_valid, ask_price,
                  ask_quantity, spread, mid_doubled, input ready);
  modport sink   (input valid, bid_valid, bid_price, bid_quantity, ask_valid, ask_price,
                  ask_quantity, spread, mid_doubled, output ready);
endinterface

`default_nettype wire

// ----- src/plb_level_update.sv -----
// Read-modify-write arithmetic for one level: add, erase, saturate, clear.
`default_nettype none

module plb_level_update (
  input  logic                         vld_i,
  input  logic                         command_i,
  input  plb_pkg::price_t              price_i,
  input  logic [plb_pkg::CHG_W-1:0]    change_i,
  input  plb_pkg::qty_t                cur_qty_i,
  output plb_pkg::lvl_wr_t             wr_o,
  output logic                         clear_o
);
  import plb_pkg::*;

  localparam int unsigned SUM_W = QTY_W + 3;

  logic signed [SUM_W-1:0] sum;
  logic                    chg_nonpos;
  logic                    skip;
  logic                    is_delta;

  // Widened signed sum of the present quantity and the change
  assign sum = $signed({3'b000, cur_qty_i}) +
               $signed({{(SUM_W-CHG_W){change_i[CHG_W-1]}}, change_i});

  // An absent level is only created by a positive change
  assign chg_nonpos = change_i[CHG_W-1] || (change_i == '0);
  assign skip       = (cur_qty_i == '0) && chg_nonpos;
  assign is_delta   = (command_i == CMD_DELTA);

  always_comb begin
    wr_o      = '0;
    wr_o.addr = price_i;
    wr_o.we   = vld_i && is_delta && price_in_range(price_i) && !skip;
    wr_o.set  = !sum[SUM_W-1] && (sum != '0);
    if (sum > $signed({3'b000, QTY_MAX})) begin
      wr_o.qty = QTY_MAX;
    end else begin
      wr_o.qty = sum[QTY_W-1:0];
    end
  end

  assign clear_o = vld_i && (command_i == CMD_CLEAR);

endmodule

`default_nettype wire

// ----- src/plb_side_store.sv -----
// One side of the book: level memory, presence bits, forwarding and top scan.
`default_nettype none

module plb_side_store (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  plb_pkg::price_t  rd_addr_i,
  input  plb_pkg::price_t  s1_addr_i,
  input  plb_pkg::lvl_wr_t wr_i,
  input  logic             clear_i,
  output plb_pkg::qty_t    cur_qty_o,
  output plb_pkg::top_t    top_o,
  output plb_pkg::qty_t    top_qty_o
);
  import plb_pkg::*;

  qty_t              mem [LEVELS];
  logic [LEVELS-1:0] valid_q, valid_d;
  qty_t              rd_q;
  qty_t              top_qty_q;
  logic              lw_vld_q;
  price_t            lw_addr_q;
  qty_t              lw_qty_q;
  logic              s1_present;
  logic              lw_hit;

  // Level memory: one write port, update read and top read, registered reads
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (wr_i.we && wr_i.set) begin
        mem[wr_i.addr] <= wr_i.qty;
      end
      rd_q      <= mem[rd_addr_i];
      top_qty_q <= mem[top_o.price];
    end
  end

  // Presence bits; a clear empties the side at once
  always_comb begin
    valid_d = valid_q;
    if (clear_i) begin
      valid_d = '0;
    end else if (wr_i.we) begin
      valid_d[wr_i.addr] = wr_i.set;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      lw_vld_q <= 1'b0;
    end else if (en_i) begin
      valid_q  <= valid_d;
      lw_vld_q <= wr_i.we && wr_i.set;
    end
  end

  // Last write, forwarded to the item whose read raced it
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lw_addr_q <= wr_i.addr;
      lw_qty_q  <= wr_i.qty;
    end
  end

  assign s1_present = price_in_range(s1_addr_i) && valid_q[s1_addr_i];
  assign lw_hit     = lw_vld_q && (lw_addr_q == s1_addr_i);

  always_comb begin
    if (!s1_present) begin
      cur_qty_o = '0;
    end else if (lw_hit) begin
      cur_qty_o = lw_qty_q;
    end else begin
      cur_qty_o = rd_q;
    end
  end

  // Highest present price
  always_comb begin
    top_o = '0;
    for (int i = 1; i < LEVELS; i++) begin
      if (valid_q[i]) begin
        top_o.present = 1'b1;
        top_o.price   = price_t'(i);
      end
    end
  end

  assign top_qty_o = top_qty_q;

endmodule

`default_nettype wire

// ----- src/price_level_book_top.sv -----
// Top level of the two-sided price level book with top-of-book reporting.
// Path: an accepted beat passes the stage-one, stage-two and stage-three registers to the output.
// Throughput: one beat per cycle; the whole three-stage pipe holds while the
//   output register waits, set by the level memory read/write in stage one.
// Reset: clears the pipe valids and the per-level presence bits of both
//   sides at once; no clearing pass, a beat may be accepted right after reset.
`default_nettype none

module price_level_book_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  plb_in_if.sink    in_i,
  plb_out_if.source out_o
);
  import plb_pkg::*;

  logic                   en;

  // Stage 1: accepted beat
  logic                   s1_vld_q;
  logic                   s1_cmd_q;
  logic                   s1_side_q;
  price_t                 s1_price_q;
  logic [CHG_W-1:0]       s1_chg_q;

  // Stage 2 and 3 controls and top-of-book payload
  logic                   s2_vld_q;
  logic                   s3_vld_q;
  logic                   s3_bid_present_q;
  price_t                 s3_bid_price_q;
  logic                   s3_ask_present_q;
  price_t                 s3_ask_price_q;
  logic [SPREAD_W-1:0]    s3_spread_q;
  logic [MID_W-1:0]       s3_mid_q;

  qty_t                   yes_cur, no_cur, cur_qty;
  qty_t                   yes_top_qty, no_top_qty;
  top_t                   yes_top, no_top;
  lvl_wr_t                upd_wr, yes_wr, no_wr;
  logic                   upd_clear;
  price_t                 ask_price_d;
  logic                   both_present;
  logic [SPREAD_W-1:0]    spread_d;
  logic [MID_W-1:0]       mid_d;

  // Pipe moves unless a result is waiting
  assign en         = !s3_vld_q || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_i.valid;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_cmd_q   <= in_i.command;
      s1_side_q  <= in_i.side;
      s1_price_q <= in_i.price;
      s1_chg_q   <= in_i.quantity_change;
    end
  end

  // Stage 1: update the addressed level
  assign cur_qty = (s1_side_q == SIDE_NO) ? no_cur : yes_cur;

  plb_level_update u_update (
    .vld_i     (s1_vld_q),
    .command_i (s1_cmd_q),
    .price_i   (s1_price_q),
    .change_i  (s1_chg_q),
    .cur_qty_i (cur_qty),
    .wr_o      (upd_wr),
    .clear_o   (upd_clear)
  );

  always_comb begin
    yes_wr    = upd_wr;
    no_wr     = upd_wr;
    yes_wr.we = upd_wr.we && (s1_side_q == SIDE_YES);
    no_wr.we  = upd_wr.we && (s1_side_q == SIDE_NO);
  end

  plb_side_store u_yes (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .rd_addr_i (in_i.price),
    .s1_addr_i (s1_price_q),
    .wr_i      (yes_wr),
    .clear_i   (upd_clear),
    .cur_qty_o (yes_cur),
    .top_o     (yes_top),
    .top_qty_o (yes_top_qty)
  );

  plb_side_store u_no (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .rd_addr_i (in_i.price),
    .s1_addr_i (s1_price_q),
    .wr_i      (no_wr),
    .clear_i   (upd_clear),
    .cur_qty_o (no_cur),
    .top_o     (no_top),
    .top_qty_o (no_top_qty)
  );

  // Stage 2: best prices, spread and doubled mid
  assign ask_price_d  = no_top.present ? (PRICE_PAR - no_top.price) : '0;
  assign both_present = yes_top.present && no_top.present;
  assign spread_d     = both_present ? ({1'b0, ask_price_d} - {1'b0, yes_top.price}) : '0;
  assign mid_d        = both_present ? ({1'b0, ask_price_d} + {1'b0, yes_top.price}) : '0;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_bid_present_q <= yes_top.present;
      s3_bid_price_q   <= yes_top.price;
      s3_ask_present_q <= no_top.present;
      s3_ask_price_q   <= ask_price_d;
      s3_spread_q      <= spread_d;
      s3_mid_q         <= mid_d;
    end
  end

  // Stage 3: result beat
  assign out_o.valid        = s3_vld_q;
  assign out_o.bid_valid    = s3_bid_present_q;
  assign out_o.bid_price    = s3_bid_price_q;
  assign out_o.bid_quantity = s3_bid_present_q ? yes_top_qty : '0;
  assign out_o.ask_valid    = s3_ask_present_q;
  assign out_o.ask_price    = s3_ask_price_q;
  assign out_o.ask_quantity = s3_ask_present_q ? no_top_qty : '0;
  assign out_o.spread       = s3_spread_q;
  assign out_o.mid_doubled  = s3_mid_q;

endmodule

`default_nettype wire

// ----- src/plb_checker.sv -----
// Port-level checks for the price level book, bound to the top level.
`default_nettype none

module plb_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_ready_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic                                bid_valid_i,
  input logic [plb_pkg::PRICE_W-1:0]         bid_price_i,
  input logic [plb_pkg::QTY_W-1:0]           bid_quantity_i,
  input logic                                ask_valid_i,
  input logic [plb_pkg::PRICE_W-1:0]         ask_price_i,
  input logic [plb_pkg::QTY_W-1:0]           ask_quantity_i,
  input logic signed [plb_pkg::SPREAD_W-1:0] spread_i,
  input logic [plb_pkg::MID_W-1:0]           mid_doubled_i
);
  import plb_pkg::*;

  // A waiting result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(bid_price_i) &&
      $stable(bid_quantity_i) && $stable(ask_price_i) && $stable(ask_quantity_i))
    else $error("result beat changed while stalled");

  // Input side is never blocked when no result is waiting
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // A present best bid always carries contracts and a nonzero price
  a_qty_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && bid_valid_i |-> (bid_quantity_i != '0) && (bid_price_i != '0))
    else $error("present bid with zero quantity or price");

  // Empty ask side reports zeros, also in spread and doubled mid
  a_empty_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !ask_valid_i |-> (ask_price_i == '0) && (ask_quantity_i == '0) &&
      (spread_i == '0) && (mid_doubled_i == '0))
    else $error("empty ask side reports nonzero fields");

  // Spread and doubled mid agree with the best prices
  a_mid_spread: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && bid_valid_i && ask_valid_i |->
      (mid_doubled_i == ({1'b0, ask_price_i} + {1'b0, bid_price_i})) &&
      (spread_i == ({1'b0, ask_price_i} - {1'b0, bid_price_i})))
    else $error("spread or mid inconsistent with best prices");

endmodule

bind price_level_book_top plb_checker u_plb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .bid_valid_i    (out_o.bid_valid),
  .bid_price_i    (out_o.bid_price),
  .bid_quantity_i (out_o.bid_quantity),
  .ask_valid_i    (out_o.ask_valid),
  .ask_price_i    (out_o.ask_price),
  .ask_quantity_i (out_o.ask_quantity),
  .spread_i       (out_o.spread),
  .mid_doubled_i  (out_o.mid_doubled)
);

`default_nettype wire

// ----- sim/plb_book_checker.sv -----
// Scoreboard for the price level book: predicts top of book per update beat and checks results.
`timescale 1ns / 1ps

module plb_book_checker (
  input  logic clk_i,
  input  logic rst_ni,
  plb_in_if    upd_i,
  plb_out_if   tob_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   beats_o,
  output int   results_o,
  output int   clears_o,
  output int   erasures_o,
  output int   saturations_o,
  output int   off_book_o,
  output int   crossed_o
);
  import plb_pkg::*;

  // One top-of-book result as the block reports it
  typedef struct packed {
    logic                bid_valid;
    price_t              bid_price;
    qty_t                bid_qty;
    logic                ask_valid;
    price_t              ask_price;
    qty_t                ask_qty;
    logic [SPREAD_W-1:0] spread;
    logic [MID_W-1:0]    mid;
  } tob_t;

  localparam int MAX_REPORTS = 100;

  // Shadow copy of both sides; zero means the level is absent
  qty_t yes_book [0:LEVELS-1];
  qty_t no_book  [0:LEVELS-1];
  tob_t tob_q [$];

  // Add a signed change to one level, erasing on zero or below, saturating at max
  function automatic void update_level(side_e s, price_t p, logic [CHG_W-1:0] raw);
    longint lvl;
    longint chg;
    if (p < PRICE_MIN || p > PRICE_MAX) begin
      off_book_o++;
      return;
    end
    chg = longint'($signed(raw));
    lvl = (s == SIDE_NO) ? longint'(no_book[p]) : longint'(yes_book[p]);
    // absent level is only created by a positive change
    if (lvl == 0 && chg <= 0) return;
    lvl = lvl + chg;
    if (lvl <= 0) begin
      lvl = 0;
      erasures_o++;
    end else if (lvl > longint'(QTY_MAX)) begin
      lvl = longint'(QTY_MAX);
      saturations_o++;
    end
    if (s == SIDE_NO) no_book[p] = qty_t'(lvl);
    else yes_book[p] = qty_t'(lvl);
  endfunction

  // Best bid from the highest yes level, best ask from 100 minus the highest no level
  function automatic tob_t top_of_book();
    tob_t t;
    int   p;
    int   bp;
    int   np;
    int   ap;
    t  = '0;
    bp = 0;
    np = 0;
    for (p = PRICE_MAX; p >= PRICE_MIN; p--) begin
      if (bp == 0 && yes_book[p] != 0) bp = p;
      if (np == 0 && no_book[p] != 0) np = p;
    end
    if (bp != 0) begin
      t.bid_valid = 1'b1;
      t.bid_price = price_t'(bp);
      t.bid_qty   = yes_book[bp];
    end
    if (np != 0) begin
      ap          = PRICE_PAR - np;
      t.ask_valid = 1'b1;
      t.ask_price = price_t'(ap);
      t.ask_qty   = no_book[np];
      if (bp != 0) begin
        t.spread = SPREAD_W'(ap - bp);
        t.mid    = MID_W'(ap + bp);
        if (ap < bp) crossed_o++;
      end
    end
    return t;
  endfunction

  task automatic check_field(string field, longint want, longint seen);
    if (want != seen) begin
      fail_count_o++;
      if (fail_count_o <= MAX_REPORTS)
        $display("%0t: result %0d %s expected %0d actual %0d",
                 $time, results_o, field, want, seen);
    end
  endtask

  // Results are checked before new updates are queued on the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    tob_t want;
    tob_t seen;
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) begin
        yes_book[i] = '0;
        no_book[i]  = '0;
      end
      tob_q.delete();
      fail_count_o  = 0;
      beats_o       = 0;
      results_o     = 0;
      clears_o      = 0;
      erasures_o    = 0;
      saturations_o = 0;
      off_book_o    = 0;
      crossed_o     = 0;
    end else begin
      if (tob_i.valid && tob_i.ready) begin
        seen = '{tob_i.bid_valid, tob_i.bid_price, tob_i.bid_quantity, tob_i.ask_valid,
                 tob_i.ask_price, tob_i.ask_quantity, tob_i.spread, tob_i.mid_doubled};
        if (tob_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MAX_REPORTS)
            $display("%0t: result beat with no update outstanding, actual %h", $time, seen);
        end else begin
          want = tob_q.pop_front();
          check_field("bid_valid", want.bid_valid, seen.bid_valid);
          check_field("bid_price", want.bid_price, seen.bid_price);
          check_field("bid_quantity", want.bid_qty, seen.bid_qty);
          check_field("ask_valid", want.ask_valid, seen.ask_valid);
          check_field("ask_price", want.ask_price, seen.ask_price);
          check_field("ask_quantity", want.ask_qty, seen.ask_qty);
          check_field("spread", $signed(want.spread), $signed(seen.spread));
          check_field("mid_doubled", want.mid, seen.mid);
        end
        results_o++;
      end
      if (upd_i.valid && upd_i.ready) begin
        if (cmd_e'(upd_i.command) == CMD_CLEAR) begin
          for (int i = 0; i < LEVELS; i++) begin
            yes_book[i] = '0;
            no_book[i]  = '0;
          end
          clears_o++;
        end else begin
          update_level(side_e'(upd_i.side), upd_i.price, upd_i.quantity_change);
        end
        tob_q.push_back(top_of_book());
        beats_o++;
      end
    end
    pending_o = tob_q.size();
  end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the price level book: clock, reset, update stimulus, result back-pressure.
`timescale 1ns / 1ps

module tb;
  import plb_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 20000;

  logic clk;
  logic rst_n;

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned hold_reqs;
  int unsigned holds_done;

  int fail_count;
  int pending;
  int beats;
  int results;
  int clears;
  int erasures;
  int saturations;
  int off_book;
  int crossed;

  plb_in_if  upd_ch ();
  plb_out_if tob_ch ();

  price_level_book_top uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (upd_ch),
    .out_o  (tob_ch)
  );

  plb_book_checker chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .upd_i         (upd_ch),
    .tob_i         (tob_ch),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .beats_o       (beats),
    .results_o     (results),
    .clears_o      (clears),
    .erasures_o    (erasures),
    .saturations_o (saturations),
    .off_book_o    (off_book),
    .crossed_o     (crossed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random stalls, plus long hold-offs on request
  initial begin
    tob_ch.ready = 1'b0;
    holds_done   = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        tob_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holds_done++;
      end else begin
        tob_ch.ready = ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Offer one update beat and hold it until accepted
  task automatic send_beat(cmd_e c, side_e s, price_t p, logic [CHG_W-1:0] chg);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      upd_ch.valid = 1'b0;
      @(negedge clk);
    end
    upd_ch.valid           = 1'b1;
    upd_ch.command         = c;
    upd_ch.side            = s;
    upd_ch.price           = p;
    upd_ch.quantity_change = chg;
    do @(posedge clk); while (!upd_ch.ready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    upd_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Mostly a narrow window so levels near the top get hit and erased
  function automatic price_t pick_price(int unsigned focus);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return '0;
    if (r < 6) return price_t'($urandom_range(127, 100));
    if (r < 26) return price_t'($urandom_range(99, 1));
    return price_t'(focus + $urandom_range(7));
  endfunction

  function automatic logic [CHG_W-1:0] pick_change();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return CHG_W'($urandom_range(500, 1));
    if (r < 65) return -CHG_W'($urandom_range(500, 1));
    if (r < 72) return '0;
    if (r < 80) return CHG_W'($urandom_range(32'h7FFF_FFFF, 32'h4000_0000));
    if (r < 86) return 32'h8000_0000 + CHG_W'($urandom_range(1000));
    return $urandom;
  endfunction

  // Random updates; a clear is always followed by a snapshot burst
  task automatic run_random(int unsigned n_items);
    int unsigned sent;
    int unsigned focus;
    int unsigned snap_len;
    logic [CHG_W-1:0] chg;
    sent  = 0;
    focus = $urandom_range(92, 1);
    while (sent < n_items) begin
      if ($urandom_range(39) == 0) focus = $urandom_range(92, 1);
      if ($urandom_range(99) < 4) begin
        send_beat(CMD_CLEAR, side_e'($urandom_range(1)), price_t'($urandom), $urandom);
        snap_len = $urandom_range(12, 3);
        for (int k = 0; k < snap_len; k++) begin
          // duplicates merge; zero or negative snapshot changes are dropped on absent levels
          if ($urandom_range(4) == 0) chg = -CHG_W'($urandom_range(3));
          else chg = CHG_W'($urandom_range(1000, 1));
          send_beat(CMD_DELTA, side_e'($urandom_range(1)), price_t'(focus + $urandom_range(4)),
                    chg);
        end
        sent += snap_len + 1;
      end else begin
        send_beat(CMD_DELTA, side_e'($urandom_range(1)), pick_price(focus), pick_change());
        sent++;
      end
    end
  endtask

  initial begin
    int errors;
    int i;
    rst_n                  = 1'b0;
    src_idle_pct           = 0;
    sink_stall_pct         = 0;
    hold_reqs              = 0;
    upd_ch.valid           = 1'b0;
    upd_ch.command         = CMD_DELTA;
    upd_ch.side            = SIDE_YES;
    upd_ch.price           = '0;
    upd_ch.quantity_change = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: price and quantity extremes, ignored cases, erase, saturate, snapshot
    send_beat(CMD_CLEAR, SIDE_YES, '0, '0);
    send_beat(CMD_DELTA, SIDE_YES, PRICE_MIN, 32'd1);
    send_beat(CMD_DELTA, SIDE_NO, PRICE_MAX, 32'd5);
    send_beat(CMD_DELTA, SIDE_YES, PRICE_MAX, 32'h7FFF_FFFF);
    send_beat(CMD_DELTA, SIDE_YES, PRICE_MAX, 32'd10);
    send_beat(CMD_DELTA, SIDE_YES, PRICE_MAX, 32'h8000_0000);
    send_beat(CMD_DELTA, SIDE_NO, PRICE_MIN, 32'd7);
    send_beat(CMD_DELTA, SIDE_NO, 7'd0, 32'd100);
    send_beat(CMD_DELTA, SIDE_YES, PRICE_PAR, 32'd5);
    send_beat(CMD_DELTA, SIDE_YES, 7'd127, 32'd5);
    send_beat(CMD_DELTA, SIDE_YES, 7'd50, 32'd0);
    send_beat(CMD_DELTA, SIDE_YES, 7'd50, -32'sd5);
    send_beat(CMD_DELTA, SIDE_YES, 7'd50, 32'd3);
    send_beat(CMD_DELTA, SIDE_YES, 7'd50, -32'sd3);
    send_beat(CMD_DELTA, SIDE_NO, PRICE_MAX, -32'sd4);
    send_beat(CMD_DELTA, SIDE_NO, PRICE_MAX, -32'sd1);
    send_beat(CMD_DELTA, SIDE_YES, PRICE_MIN, 32'd0);
    send_beat(CMD_CLEAR, SIDE_NO, 7'h7F, 32'hFFFF_FFFF);
    send_beat(CMD_DELTA, SIDE_YES, 7'd40, 32'd10);
    send_beat(CMD_DELTA, SIDE_YES, 7'd40, 32'd5);
    send_beat(CMD_DELTA, SIDE_YES, 7'd41, -32'sd3);
    send_beat(CMD_DELTA, SIDE_NO, 7'd55, 32'd20);
    send_beat(CMD_DELTA, SIDE_NO, 7'd55, 32'd0);
    send_beat(CMD_DELTA, SIDE_YES, 7'd60, 32'd1);
    wait_drained();

    // No idling, with a long result hold-off while updates keep coming
    hold_reqs++;
    run_random(350);
    wait_drained();

    src_idle_pct = 47;
    run_random(350);
    wait_drained();

    src_idle_pct   = 0;
    sink_stall_pct = 47;
    run_random(350);
    wait_drained();

    src_idle_pct   = 19;
    sink_stall_pct = 19;
    hold_reqs++;
    run_random(350);

    @(negedge clk);
    upd_ch.valid = 1'b0;
    for (i = 0; i < DRAIN_LIMIT && pending != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);

    errors = fail_count;
    if (pending != 0) begin
      $display("%0t: %0d results never arrived", $time, pending);
      errors++;
    end
    $display("Run covered %0d update beats and %0d results, incl. %0d clears.",
             beats, results, clears);
    $display("Book events: %0d erasures, %0d saturations, %0d off-book prices, %0d crossed.",
             erasures, saturations, off_book, crossed);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- price_level_book_top.f -----
src/plb_pkg.sv
src/plb_if.sv
src/plb_level_update.sv
src/plb_side_store.sv
src/price_level_book_top.sv
src/plb_checker.sv
sim/plb_book_checker.sv
sim/tb.sv
